// ===== hdl/hepr_pkg.sv =====
// Shared types, constants and SHA-256 helper functions for the entropy pool.
// No dependencies.
`default_nettype none

package hepr_pkg;

	// input action codes
	localparam logic [1:0] ACT_FEED = 2'd0;
	localparam logic [1:0] ACT_READ = 2'd1;
	localparam logic [1:0] ACT_DRAW = 2'd2;

	localparam int BLOCK_BYTES  = 64;
	localparam int DIGEST_BYTES = 32;
	localparam int FEEDBACK_BYTES = 2;
	localparam int COUNT_W = 61;

	// hash state: word 0 is a, word 7 is h
	typedef logic [7:0][31:0] hstate_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_ROUND,
		S_ADD,
		S_FEED,
		S_EMIT,
		S_SCAN,
		S_ZERO
	} state_t;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam hstate_t INITIAL_H = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	// next schedule word from the 16-word window
	function automatic logic [31:0] sched_next(input logic [31:0] w0, input logic [31:0] w1,
			input logic [31:0] w9, input logic [31:0] w14);
		logic [31:0] s0;
		logic [31:0] s1;
		s0 = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
		s1 = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
		sched_next = w0 + s0 + w9 + s1;
	endfunction

	// one compression round
	function automatic hstate_t sha_round(input hstate_t v, input logic [31:0] k,
			input logic [31:0] w);
		logic [31:0] t1;
		logic [31:0] t2;
		hstate_t r;
		t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) +
			((v[4] & v[5]) ^ (~v[4] & v[6])) + k + w;
		t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) +
			((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
		r[7] = v[6];
		r[6] = v[5];
		r[5] = v[4];
		r[4] = v[3] + t1;
		r[3] = v[2];
		r[2] = v[1];
		r[1] = v[0];
		r[0] = t1 + t2;
		sha_round = r;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/hepr_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module hepr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/hash_entropy_pool_rng.sv =====
// SHA-256 entropy pool top level: feed, digest read and bounded draw.
// Depends on hepr_pkg and hepr_ram (64-byte message block memory).
//
// Usage: one input channel (in_valid/in_ready) carries action, data_byte
// and max_value; one output channel (out_valid/out_ready) carries out_byte
// and last. A feed word absorbs one byte and, when it completes a 64-byte
// block, runs a compression (load of the block from the block memory, 64
// rounds at one round a cycle, final add). A read finalizes a copy of the
// pool (one or two compressions), absorbs the first two digest bytes back
// (one more compression if that crosses a block), then emits 32 words, one
// a cycle while the receiver takes them; last marks the 32nd. A draw does
// the same finalize and feedback, then scans the digest one byte a cycle and
// emits one word; a scan with no fitting byte starts another finalize and
// feedback. A draw with zero bound answers 0 with no hashing. The
// compression loop sets the rate: one item is worked on at a time and
// in_ready is high only while idle. A stalled receiver holds the output
// register and the engine waits. Reset loads the SHA-256 initial hash and
// clears the byte count; the block memory is not cleared.
`default_nettype none

module hash_entropy_pool_rng (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] action,
	input  wire logic [7:0] data_byte,
	input  wire logic [7:0] max_value,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic      [7:0] out_byte,
	output logic            last
);

	import hepr_pkg::*;

	state_t state_q, state_d;

	hstate_t chain_q;
	hstate_t fin_q;
	hstate_t v_q;
	hstate_t hsum;
	logic [511:0] wblk_q;
	logic [COUNT_W-1:0] count_q;
	logic [6:0] cnt_q;
	logic tgt_fin_q, fin_blk_q, two_blk_q, ret_feed_q, draw_q;
	logic [1:0] fb_k_q;
	logic [4:0] idx_q;
	logic [7:0] max_q;
	logic out_valid_q, last_q;
	logic [7:0] out_byte_q;

	logic [5:0] pos;
	logic acc, out_free, out_load;
	logic ram_we;
	logic [5:0] ram_waddr;
	logic [7:0] ram_wdata, ram_rdata;
	logic [5:0] ld_j;
	logic [7:0] ld_byte;
	logic [63:0] bit_len;
	logic [31:0] w_new;
	logic [7:0] dig_byte, fb_byte, mask, masked;
	logic hit;

	assign pos      = count_q[5:0];
	assign in_ready = (state_q == S_IDLE);
	assign acc      = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign bit_len  = {count_q, 3'b000};

	// message block memory
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = pos;
		ram_wdata = data_byte;
		if (acc && action == ACT_FEED) begin
			ram_we = 1'b1;
		end else if (state_q == S_FEED && fb_k_q != 2'(FEEDBACK_BYTES)) begin
			ram_we    = 1'b1;
			ram_wdata = fb_byte;
		end
	end

	hepr_ram #(
		.WIDTH(8),
		.DEPTH(BLOCK_BYTES)
	) u_block_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (cnt_q[5:0]),
		.rdata (ram_rdata)
	);

	// byte that enters the schedule during a block load (padding for finalize)
	assign ld_j = cnt_q[5:0] - 6'd1;
	always_comb begin
		ld_byte = ram_rdata;
		if (tgt_fin_q) begin
			ld_byte = 8'h00;
			if (!fin_blk_q) begin
				if (ld_j < pos) begin
					ld_byte = ram_rdata;
				end else if (ld_j == pos) begin
					ld_byte = 8'h80;
				end else if (!two_blk_q && ld_j >= 6'd56) begin
					ld_byte = bit_len[63 - 8 * ld_j[2:0] -: 8];
				end
			end else if (ld_j >= 6'd56) begin
				ld_byte = bit_len[63 - 8 * ld_j[2:0] -: 8];
			end
		end
	end

	// schedule word and chaining add
	assign w_new = sched_next(wblk_q[511 -: 32], wblk_q[479 -: 32], wblk_q[223 -: 32],
		wblk_q[63 -: 32]);
	always_comb begin
		for (int i = 0; i < 8; i++) begin
			hsum[i] = (tgt_fin_q ? fin_q[i] : chain_q[i]) + v_q[i];
		end
	end

	// digest byte selection and draw compare
	assign dig_byte = fin_q[idx_q[4:2]][31 - 8 * idx_q[1:0] -: 8];
	assign fb_byte  = fb_k_q[0] ? fin_q[0][23:16] : fin_q[0][31:24];
	assign mask     = max_q | (max_q >> 1) | (max_q >> 2) | (max_q >> 3) |
		(max_q >> 4) | (max_q >> 5) | (max_q >> 6) | (max_q >> 7);
	assign masked   = dig_byte & mask;
	assign hit      = masked <= max_q;

	// output register load
	assign out_load = out_free && (state_q == S_EMIT || state_q == S_ZERO ||
		(state_q == S_SCAN && hit));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					case (action)
						ACT_FEED: state_d = (pos == 6'd63) ? S_LOAD : S_IDLE;
						ACT_READ: state_d = S_LOAD;
						ACT_DRAW: state_d = (max_value == 8'd0) ? S_ZERO : S_LOAD;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_LOAD: begin
				if (cnt_q == 7'd64) state_d = S_ROUND;
			end
			S_ROUND: begin
				if (cnt_q == 7'd63) state_d = S_ADD;
			end
			S_ADD: begin
				if (!tgt_fin_q) begin
					state_d = ret_feed_q ? S_FEED : S_IDLE;
				end else if (two_blk_q && !fin_blk_q) begin
					state_d = S_LOAD;
				end else begin
					state_d = S_FEED;
				end
			end
			S_FEED: begin
				if (fb_k_q == 2'(FEEDBACK_BYTES)) begin
					state_d = draw_q ? S_SCAN : S_EMIT;
				end else if (pos == 6'd63) begin
					state_d = S_LOAD;
				end
			end
			S_EMIT: begin
				if (out_free && idx_q == 5'(DIGEST_BYTES - 1)) state_d = S_IDLE;
			end
			S_SCAN: begin
				if (hit && out_free) begin
					state_d = S_IDLE;
				end else if (!hit && idx_q == 5'(DIGEST_BYTES - 1)) begin
					state_d = S_LOAD;
				end
			end
			S_ZERO: begin
				if (out_free) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control and pool state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q     <= INITIAL_H;
			count_q     <= '0;
			cnt_q       <= '0;
			tgt_fin_q   <= 1'b0;
			fin_blk_q   <= 1'b0;
			two_blk_q   <= 1'b0;
			ret_feed_q  <= 1'b0;
			draw_q      <= 1'b0;
			fb_k_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						draw_q <= (action == ACT_DRAW);
						cnt_q  <= '0;
						if (action == ACT_FEED) begin
							count_q    <= count_q + 1'b1;
							tgt_fin_q  <= 1'b0;
							ret_feed_q <= 1'b0;
						end else if (action == ACT_READ ||
								(action == ACT_DRAW && max_value != 8'd0)) begin
							tgt_fin_q <= 1'b1;
							fin_blk_q <= 1'b0;
							two_blk_q <= pos > 6'd55;
							fb_k_q    <= '0;
							idx_q     <= '0;
						end
					end
				end
				S_LOAD: begin
					cnt_q <= (cnt_q == 7'd64) ? 7'd0 : cnt_q + 7'd1;
				end
				S_ROUND: begin
					cnt_q <= cnt_q + 7'd1;
				end
				S_ADD: begin
					cnt_q <= '0;
					if (tgt_fin_q) begin
						fin_blk_q <= 1'b1;
					end else begin
						chain_q <= hsum;
					end
				end
				S_FEED: begin
					if (fb_k_q != 2'(FEEDBACK_BYTES)) begin
						count_q <= count_q + 1'b1;
						fb_k_q  <= fb_k_q + 2'd1;
						if (pos == 6'd63) begin
							tgt_fin_q  <= 1'b0;
							ret_feed_q <= 1'b1;
							cnt_q      <= '0;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						idx_q <= idx_q + 5'd1;
					end
				end
				S_SCAN: begin
					if (!hit) begin
						if (idx_q == 5'(DIGEST_BYTES - 1)) begin
							tgt_fin_q <= 1'b1;
							fin_blk_q <= 1'b0;
							two_blk_q <= pos > 6'd55;
							fb_k_q    <= '0;
							idx_q     <= '0;
							cnt_q     <= '0;
						end else begin
							idx_q <= idx_q + 5'd1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					max_q <= max_value;
					v_q   <= chain_q;
					if (action != ACT_FEED) fin_q <= chain_q;
				end
			end
			S_LOAD: begin
				if (cnt_q != 7'd0) wblk_q <= {wblk_q[503:0], ld_byte};
			end
			S_ROUND: begin
				v_q    <= sha_round(v_q, ROUND_K[cnt_q[5:0]], wblk_q[511 -: 32]);
				wblk_q <= {wblk_q[479:0], w_new};
			end
			S_ADD: begin
				if (tgt_fin_q) fin_q <= hsum;
				v_q <= hsum;
			end
			S_FEED: begin
				v_q <= chain_q;
			end
			S_EMIT: begin
				if (out_free) begin
					out_byte_q <= dig_byte;
					last_q     <= (idx_q == 5'(DIGEST_BYTES - 1));
				end
			end
			S_SCAN: begin
				if (hit && out_free) begin
					out_byte_q <= masked;
					last_q     <= 1'b1;
				end else if (!hit && idx_q == 5'(DIGEST_BYTES - 1)) begin
					fin_q <= chain_q;
					v_q   <= chain_q;
				end
			end
			S_ZERO: begin
				if (out_free) begin
					out_byte_q <= 8'd0;
					last_q     <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	// a new output word is only produced by the emitting states
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_EMIT || $past(state_q) == S_SCAN ||
			$past(state_q) == S_ZERO))
		else $error("output word from a non-emitting state");

	// the block load counter never runs past the block
	a_load_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> (cnt_q <= 7'd64))
		else $error("block load counter overrun");

	// feedback never absorbs more than two digest bytes
	a_fb_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		fb_k_q <= 2'(FEEDBACK_BYTES))
		else $error("feedback count overrun");

	// the byte count only moves when a byte is written to the block memory
	a_count_we: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> $past(ram_we))
		else $error("byte count moved without a block write");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for hash_entropy_pool_rng: drives feed, read and draw words and
// checks every output word against a SHA-256 pool predictor kept in the bench.
// Depends on hepr_pkg (action codes, sizes) and the RTL top level.
`timescale 1ns / 1ps
`default_nettype none

module tb;
	import hepr_pkg::*;

	typedef struct packed {
		logic [1:0] act;
		logic [7:0] dbyte;
		logic [7:0] maxv;
	} word_t;

	typedef struct packed {
		logic [7:0] obyte;
		logic       olast;
	} result_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] action;
	logic [7:0] data_byte;
	logic [7:0] max_value;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] out_byte;
	logic       last;

	hash_entropy_pool_rng uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .data_byte(data_byte), .max_value(max_value),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_byte(out_byte), .last(last)
	);

	// predictor state
	logic [31:0] pool_h [8];
	logic [7:0]  pool_blk [64];
	logic [60:0] pool_count;

	word_t   pending_words[$];
	result_t expected_words[$];
	int      errors = 0;
	int      n_words = 0;
	int      n_results = 0;
	bit      stim_done = 0;
	bit      hold_off = 0;

	logic [31:0] kc [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror32(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// one sha-256 block compression into h
	task automatic sha_block(inout logic [31:0] h [8], input logic [7:0] blk [64]);
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = w[t-16] + s0 + w[t-7] + s1;
		end
		v = h;
		for (int t = 0; t < 64; t++) begin
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
				((v[4] & v[5]) ^ (~v[4] & v[6])) + kc[t] + w[t];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
				((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int t = 0; t < 8; t++)
			h[t] = h[t] + v[t];
	endtask

	task automatic pool_absorb(logic [7:0] b);
		int pos;
		pos = pool_count[5:0];
		pool_blk[pos] = b;
		pool_count = pool_count + 1;
		if (pos == 63)
			sha_block(pool_h, pool_blk);
	endtask

	// finalize a copy of the pool, then feed back the first digest bytes
	task automatic pool_digest(output logic [7:0] dig [32]);
		logic [31:0] h [8];
		logic [7:0]  blk [64];
		logic [63:0] nbits;
		int pos;
		h = pool_h;
		blk = pool_blk;
		pos = pool_count[5:0];
		nbits = {pool_count, 3'b000};
		blk[pos] = 8'h80;
		pos++;
		if (pos > 56) begin
			while (pos < 64) begin
				blk[pos] = 0;
				pos++;
			end
			sha_block(h, blk);
			pos = 0;
		end
		while (pos < 56) begin
			blk[pos] = 0;
			pos++;
		end
		for (int i = 0; i < 8; i++)
			blk[56+i] = nbits[63-8*i -: 8];
		sha_block(h, blk);
		for (int i = 0; i < DIGEST_BYTES; i++)
			dig[i] = h[i/4][31-8*(i%4) -: 8];
		for (int i = 0; i < FEEDBACK_BYTES; i++)
			pool_absorb(dig[i]);
	endtask

	// expected output words for one accepted input word
	task automatic predict_pool(word_t wd);
		logic [7:0] dig [32];
		logic [7:0] mask, v;
		bit found;
		case (wd.act)
			ACT_FEED: pool_absorb(wd.dbyte);
			ACT_READ: begin
				pool_digest(dig);
				for (int i = 0; i < DIGEST_BYTES; i++)
					expected_words.push_back('{dig[i], i == DIGEST_BYTES - 1});
			end
			ACT_DRAW: begin
				if (wd.maxv == 0) begin
					expected_words.push_back('{8'd0, 1'b1});
				end else begin
					mask = 0;
					while (mask < wd.maxv)
						mask = (mask << 1) | 8'd1;
					found = 0;
					while (!found) begin
						pool_digest(dig);
						for (int i = 0; i < DIGEST_BYTES && !found; i++) begin
							v = dig[i] & mask;
							if (v <= wd.maxv) begin
								found = 1;
								expected_words.push_back('{v, 1'b1});
							end
						end
					end
				end
			end
			default: ;
		endcase
	endtask

	// clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// stimulus list
	initial begin
		word_t wd;
		int r;
		pool_h = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		foreach (pool_blk[i]) pool_blk[i] = 0;
		pool_count = 0;
		// directed: read of empty pool, field extremes, zero bound, unused code
		pending_words.push_back('{ACT_READ, 8'h00, 8'h00});
		pending_words.push_back('{ACT_FEED, 8'h00, 8'hff});
		pending_words.push_back('{ACT_FEED, 8'hff, 8'h00});
		pending_words.push_back('{ACT_DRAW, 8'h00, 8'h00});
		pending_words.push_back('{ACT_DRAW, 8'hff, 8'd1});
		pending_words.push_back('{ACT_DRAW, 8'h00, 8'd255});
		pending_words.push_back('{ACT_DRAW, 8'h00, 8'd128});
		pending_words.push_back('{ACT_DRAW, 8'h00, 8'd129});
		pending_words.push_back('{2'd3, 8'haa, 8'h55});
		pending_words.push_back('{ACT_READ, 8'hff, 8'hff});
		pending_words.push_back('{ACT_DRAW, 8'h00, 8'd2});
		pending_words.push_back('{ACT_READ, 8'h00, 8'h00});
		// random: feed-heavy so blocks fill and padding crosses boundaries
		for (int i = 0; i < 160; i++) begin
			r = $urandom_range(0, 99);
			wd.dbyte = $urandom;
			wd.maxv = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
			if (r < 62) wd.act = ACT_FEED;
			else if (r < 78) wd.act = ACT_READ;
			else if (r < 96) wd.act = ACT_DRAW;
			else wd.act = 2'd3;
			pending_words.push_back(wd);
		end
	end

	// reset and input defaults
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = ACT_FEED;
		data_byte = 0;
		max_value = 0;
		out_ready = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// driver
	int send_gap = 0;
	always @(posedge clk) begin
		word_t wd;
		if (arst_n && !stim_done) begin
			if (in_valid && in_ready) begin
				predict_pool({action, data_byte, max_value});
				n_words++;
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0) begin
					in_valid <= 1'b0;
					send_gap--;
				end else if (pending_words.size() > 0) begin
					wd = pending_words.pop_front();
					in_valid <= 1'b1;
					action <= wd.act;
					data_byte <= wd.dbyte;
					max_value <= wd.maxv;
					send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
				end else begin
					in_valid <= 1'b0;
					stim_done = 1;
				end
			end
		end
	end

	// receiver: random stalls, with one long hold-off
	int hold_cnt = 0;
	int recv_gap = 0;
	always @(posedge clk) begin
		result_t exp_w;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_results++;
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word out_byte=%h last=%b", $time, out_byte, last);
					errors++;
				end else begin
					exp_w = expected_words.pop_front();
					if (out_byte !== exp_w.obyte || last !== exp_w.olast) begin
						$display("%0t: mismatch expected byte=%h last=%b actual byte=%h last=%b",
							$time, exp_w.obyte, exp_w.olast, out_byte, last);
						errors++;
					end
				end
				recv_gap = $urandom_range(0, 10);
			end
			if (n_words == 20 && !hold_off) begin
				hold_off = 1;
				hold_cnt = 600;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				out_ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// end of run
	initial begin
		wait (stim_done);
		wait (expected_words.size() == 0);
		repeat (500) @(posedge clk);
		$display("covered %0d input words, %0d output words checked", n_words, n_results);
		if (errors == 0 && expected_words.size() == 0)
			$display("hash_entropy_pool_rng verification clean");
		else
			$display("hash_entropy_pool_rng verification failed");
		$finish;
	end

	// timeout
	initial begin
		#20ms;
		$display("hash_entropy_pool_rng verification failed");
		$finish;
	end

endmodule

`default_nettype wire
